// ===== rtl/core/ame_pkg.sv =====
// Shared types and constants for the accumulator machine execute core.
package ame_pkg;

  // Default sizing of the core
  localparam int unsigned MemWordsDef  = 10;
  localparam int unsigned DataWidthDef = 32;

  // Fixed field widths
  localparam int unsigned PcW     = 9;
  localparam int unsigned StatW   = 3;
  localparam int unsigned PortW   = 32;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 80;

  // Counter value used for a jump before the first line
  localparam logic [PcW-1:0] PcPastEnd = 9'd256;

  typedef enum logic [7:0] {
    OP_ADD  = 8'd1,
    OP_SUB  = 8'd2,
    OP_MUL  = 8'd3,
    OP_DIV  = 8'd4,
    OP_LD   = 8'd5,
    OP_LDC  = 8'd6,
    OP_ST   = 8'd7,
    OP_IN   = 8'd8,
    OP_OUT  = 8'd9,
    OP_HALT = 8'd10,
    OP_JMP  = 8'd11,
    OP_JZ   = 8'd12,
    OP_JNZ  = 8'd13,
    OP_JN   = 8'd14,
    OP_JLE  = 8'd15,
    OP_JGT  = 8'd16,
    OP_JGE  = 8'd17
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_RUN      = 3'd0,
    ST_HALTED   = 3'd1,
    ST_OFF_PROG = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_BAD_ADDR = 3'd4,
    ST_DIV_ZERO = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_NEG_A,
    S_NEG_B,
    S_MUL,
    S_DIV,
    S_DIV_FIX,
    S_WB
  } seq_state_e;

endpackage

// ===== rtl/core/accumulator_machine_execute_core.sv =====
// Accumulator machine execute core: one instruction per input beat.
//
// Channel   Dir  Handshake                 Content
// s_axis    in   s_axis_tvalid/tready      instruction beat
// m_axis    out  m_axis_tvalid/tready      result beat
// cfg       in   cfg_valid_i/cfg_ready_o   program length
//
// Simple instructions pass from accept through execute and write-back to the next ready.
// Multiply iterates in its multiply step; divide runs its negate, divide and sign steps;
// both run one step per cycle through the single shared adder.
// Reset clears accumulator, counter, status, data memory valid bits and program length.
// A held result beat does not block the next accept; a second finished
// result waits in the write-back step until the output register drains.
module accumulator_machine_execute_core
  import ame_pkg::*;
#(
  parameter int unsigned MEM_WORDS  = MemWordsDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PcW-1:0]      cfg_data_i,
  // Instruction stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] opcode, [15:8] operand, [47:16] in_value
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] is_comment
  input  logic                s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [8:0] next_pc, [11:9] status, [43:12] out_value, [75:44] acc_value
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] out_valid
  output logic                m_axis_tuser
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CW = $clog2(DW);
  localparam logic [PcW-1:0] MemWordsC = PcW'(MEM_WORDS);
  localparam logic [CW-1:0] LastStep = CW'(DW - 1);

  // Sequencer and machine state
  seq_state_e        state_q, state_d;
  logic [DW-1:0]     acc_q, acc_d;
  logic [PcW-1:0]    pc_q, pc_d;
  logic [StatW-1:0]  stat_q, stat_d;
  logic              stop_q, stop_d;
  logic [PcW-1:0]    plen_q;

  // Latched instruction
  logic              cmt_q;
  logic [7:0]        op_q;
  logic [7:0]        arg_q;
  logic [DW-1:0]     inv_q;
  logic [AW-1:0]     idx_q;

  // Data memory with per-word valid bits
  logic [DW-1:0]        mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  logic [DW-1:0]        rd_q;
  logic                 rdok_q;
  logic                 mem_we;
  logic [DW-1:0]        mem_wdata;

  // Iteration registers of the shared unit
  logic [DW-1:0]     wa_q, wa_d;
  logic [DW-1:0]     wb_q, wb_d;
  logic [DW-1:0]     wc_q, wc_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              sgn_q, sgn_d;
  logic              ov_q, ov_d;
  logic [DW-1:0]     ovv_q, ovv_d;

  // Output register
  logic                m_vld_q, m_vld_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_user_q, m_user_d;

  // Input field view
  logic [7:0]        in_op, in_arg;
  logic [PortW-1:0]  in_val;
  logic [63:0]       in_sext;
  logic              in_rng;
  logic [AW-1:0]     in_idx;
  logic              acc_in;

  // Shared adder
  logic [DW-1:0]     add_a, add_b;
  logic              add_sub;
  logic [DW:0]       add_s;

  // Misc
  logic [63:0]       acc64, ovv64;
  logic [PcW-1:0]    pc_inc, jmp_tgt;
  logic              arg_rng;

  assign in_op   = s_axis_tdata[7:0];
  assign in_arg  = s_axis_tdata[15:8];
  assign in_val  = s_axis_tdata[47:16];
  assign in_sext = 64'(signed'(in_val));
  assign in_rng  = {1'b0, in_arg} < MemWordsC;
  assign in_idx  = in_rng ? in_arg[AW-1:0] : '0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign add_s = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (DW + 1)'(add_sub);

  assign acc64   = 64'(acc_q);
  assign ovv64   = 64'(ovv_q);
  assign pc_inc  = pc_q + 9'd1;
  assign jmp_tgt = (arg_q == 8'd0) ? PcPastEnd : ({1'b0, arg_q} - 9'd1);
  assign arg_rng = {1'b0, arg_q} < MemWordsC;

  // Next state, datapath control
  always_comb begin
    logic [DW-1:0]  w;
    logic           fin;
    logic [PcW-1:0] fin_pc;
    logic           zero_a, neg_a, taken;
    logic [DW-1:0]  sh;

    state_d   = state_q;
    acc_d     = acc_q;
    pc_d      = pc_q;
    stat_d    = stat_q;
    stop_d    = stop_q;
    wa_d      = wa_q;
    wb_d      = wb_q;
    wc_d      = wc_q;
    cnt_d     = cnt_q;
    sgn_d     = sgn_q;
    ov_d      = ov_q;
    ovv_d     = ovv_q;
    m_vld_d   = m_vld_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    mem_wdata = acc_q;
    add_a     = acc_q;
    add_b     = '0;
    add_sub   = 1'b0;
    fin       = 1'b0;
    fin_pc    = pc_inc;
    taken     = 1'b0;
    w         = rdok_q ? rd_q : '0;
    zero_a    = (acc_q == '0);
    neg_a     = acc_q[DW-1];
    sh        = {wa_q[DW-2:0], wc_q[DW-1]};

    case (state_q)
      S_IDLE: begin
        if (acc_in) state_d = S_EXEC;
      end

      // Decode, execute the simple instructions and start multiply or divide
      S_EXEC: begin
        state_d = S_WB;
        ov_d    = 1'b0;
        ovv_d   = '0;
        if (stop_q) begin
          // machine already stopped: repeat state
        end else if (pc_q >= plen_q) begin
          stop_d = 1'b1;
          stat_d = ST_OFF_PROG;
        end else if (cmt_q) begin
          fin = 1'b1;
        end else if (!(op_q inside {[OP_ADD:OP_JGE]})) begin
          stop_d = 1'b1;
          stat_d = ST_BAD_OP;
        end else if ((op_q inside {[OP_ADD:OP_LD], [OP_ST:OP_OUT]}) && !arg_rng) begin
          stop_d = 1'b1;
          stat_d = ST_BAD_ADDR;
        end else begin
          case (opcode_e'(op_q))
            OP_ADD: begin
              add_b = w;
              acc_d = add_s[DW-1:0];
              fin   = 1'b1;
            end
            OP_SUB: begin
              add_b   = w;
              add_sub = 1'b1;
              acc_d   = add_s[DW-1:0];
              fin     = 1'b1;
            end
            OP_MUL: begin
              wa_d    = '0;
              wb_d    = acc_q;
              wc_d    = w;
              cnt_d   = '0;
              state_d = S_MUL;
            end
            OP_DIV: begin
              if (w == '0) begin
                stop_d = 1'b1;
                stat_d = ST_DIV_ZERO;
              end else begin
                wa_d    = '0;
                wb_d    = w;
                wc_d    = acc_q;
                sgn_d   = acc_q[DW-1] ^ w[DW-1];
                state_d = S_NEG_A;
              end
            end
            OP_LD: begin
              acc_d = w;
              fin   = 1'b1;
            end
            OP_LDC: begin
              acc_d = DW'(arg_q);
              fin   = 1'b1;
            end
            OP_ST: begin
              mem_we = 1'b1;
              fin    = 1'b1;
            end
            OP_IN: begin
              mem_we    = 1'b1;
              mem_wdata = inv_q;
              fin       = 1'b1;
            end
            OP_OUT: begin
              ov_d  = 1'b1;
              ovv_d = w;
              fin   = 1'b1;
            end
            OP_HALT: begin
              stop_d = 1'b1;
              stat_d = ST_HALTED;
            end
            OP_JMP: taken = 1'b1;
            OP_JZ:  taken = zero_a;
            OP_JNZ: taken = !zero_a;
            OP_JN:  taken = neg_a;
            OP_JLE: taken = neg_a || zero_a;
            OP_JGT: taken = !neg_a && !zero_a;
            OP_JGE: taken = !neg_a;
            default: ;
          endcase
          if (op_q inside {[OP_JMP:OP_JGE]}) begin
            fin = 1'b1;
            if (taken) fin_pc = jmp_tgt;
          end
        end
      end

      // Shift-add multiply, one multiplier bit per cycle
      S_MUL: begin
        add_a = wa_q;
        add_b = wb_q;
        if (wc_q[0]) wa_d = add_s[DW-1:0];
        wb_d  = {wb_q[DW-2:0], 1'b0};
        wc_d  = {1'b0, wc_q[DW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          acc_d = wc_q[0] ? add_s[DW-1:0] : wa_q;
          fin   = 1'b1;
        end
      end

      // Dividend magnitude
      S_NEG_A: begin
        add_a   = '0;
        add_b   = wc_q;
        add_sub = 1'b1;
        if (wc_q[DW-1]) wc_d = add_s[DW-1:0];
        state_d = S_NEG_B;
      end

      // Divisor magnitude
      S_NEG_B: begin
        add_a   = '0;
        add_b   = wb_q;
        add_sub = 1'b1;
        if (wb_q[DW-1]) wb_d = add_s[DW-1:0];
        cnt_d   = '0;
        state_d = S_DIV;
      end

      // Restoring divide, one quotient bit per cycle
      S_DIV: begin
        add_a   = sh;
        add_b   = wb_q;
        add_sub = 1'b1;
        wa_d    = add_s[DW] ? add_s[DW-1:0] : sh;
        wc_d    = {wc_q[DW-2:0], add_s[DW]};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LastStep) state_d = S_DIV_FIX;
      end

      // Quotient sign
      S_DIV_FIX: begin
        add_a   = '0;
        add_b   = wc_q;
        add_sub = 1'b1;
        acc_d   = sgn_q ? add_s[DW-1:0] : wc_q;
        fin     = 1'b1;
      end

      // Move the result into the output register
      S_WB: begin
        if (!m_vld_q || m_axis_tready) begin
          m_vld_d  = 1'b1;
          m_data_d = {4'b0, acc64[PortW-1:0], ovv64[PortW-1:0], stat_q, pc_q};
          m_user_d = ov_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Normal completion: advance the counter, stop past the program
    if (fin) begin
      pc_d    = fin_pc;
      state_d = S_WB;
      if (fin_pc >= plen_q) begin
        stop_d = 1'b1;
        stat_d = ST_OFF_PROG;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      pc_q    <= '0;
      stat_q  <= ST_RUN;
      stop_q  <= 1'b0;
      plen_q  <= '0;
      vld_q   <= '0;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      stat_q  <= stat_d;
      stop_q  <= stop_d;
      m_vld_q <= m_vld_d;
      if (cfg_valid_i) plen_q <= cfg_data_i;
      if (mem_we) vld_q[idx_q] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cmt_q <= s_axis_tuser;
      op_q  <= in_op;
      arg_q <= in_arg;
      inv_q <= in_sext[DW-1:0];
      idx_q <= in_idx;
    end
    wa_q     <= wa_d;
    wb_q     <= wb_d;
    wc_q     <= wc_d;
    cnt_q    <= cnt_d;
    sgn_q    <= sgn_d;
    ov_q     <= ov_d;
    ovv_q    <= ovv_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // Data memory: write in execute, registered read at accept
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx_q] <= mem_wdata;
    if (acc_in) begin
      rd_q   <= mem[in_idx];
      rdok_q <= vld_q[in_idx];
    end
  end

endmodule
